[rtl/quadrature_count_period_speed_assert.svh]
// Assertion macros shared by the RTL files.
// QCPS_ASSERT is checked only out of reset; QCPS_ASSERT_ALWAYS also during reset.
`ifndef QUADRATURE_COUNT_PERIOD_SPEED_ASSERT_SVH
`define QUADRATURE_COUNT_PERIOD_SPEED_ASSERT_SVH
`ifndef SYNTH
`define QCPS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("qcps assertion failed");
`define QCPS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("qcps assertion failed");
`else
`define QCPS_ASSERT(lbl, clk, rst, prop)
`define QCPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/qcps_pkg.sv]
`default_nettype none
package qcps_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned SCALE_W = 40;
   localparam int unsigned CNT_W   = 32;
   localparam int unsigned SPEED_W = 32;

   // divider: scale over period magnitude (at most 2^31-1)
   localparam int unsigned DIV_N_W = SCALE_W;
   localparam int unsigned DIV_D_W = 31;
   localparam int unsigned DIV_C_W = $clog2(DIV_N_W + 1);

   localparam int unsigned CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_TIMEOUT = 8'd1;

   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [SPEED_W-1:0] SPEED_MAX       = 32'h7FFF_FFFF;
   localparam logic [TIME_W-1:0]  TIMEOUT_RESET   = 32'd10000;
   localparam logic [TIME_W-1:0]  LAST_TIME_RESET = 32'd1;
   localparam logic [TIME_W-1:0]  PERIOD_RESET    = 32'd10000000;

endpackage
`default_nettype wire

[rtl/quadrature_count_period_speed.sv]
`default_nettype none
// Channel   Ports                                   Moves
// req       req_tvalid/tready, tdata[39:0], tuser    edge or query transaction
// rsp       rsp_tvalid/tready, tdata[103:0]          one result transaction per req
// csr       csr_valid/ready, csr_index, csr_data     register write
//
// Edge transactions: result registered on the next edge after acceptance.
// Queries: stopped or zero-period answered the same way; otherwise the radix-2
//   divider runs and the result is registered once it signals done.
// req_tready is low while the divider runs and while an unread result would be
//   overwritten. csr_ready is always high. Reset is synchronous, active high.
`include "quadrature_count_period_speed_assert.svh"
module quadrature_count_period_speed
   import qcps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // config write port
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SCALE_W-1:0]   csr_data,
   // request stream
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [39:0]          req_tdata,  // phase_a, phase_b, now_us[31:0], pad
   input  wire logic [0:0]           req_tuser,  // operation
   // result stream
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [103:0]              rsp_tdata   // position, signed_period_us, speed,
                                                 // stopped, pad
);

   typedef enum logic {ST_IDLE, ST_DIV} state_type;

   state_type           state_ff, state_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [TIME_W-1:0]   timeout_ff, timeout_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TIME_W-1:0]   last_time_ff, last_time_in;
   logic [TIME_W-1:0]   last_period_ff, last_period_in;
   logic                neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    out_pos_ff, out_pos_in;
   logic [TIME_W-1:0]   out_period_ff, out_period_in;
   logic [SPEED_W-1:0]  out_speed_ff, out_speed_in;
   logic                out_stopped_ff, out_stopped_in;

   logic                req_op, req_pa, req_pb;
   logic [TIME_W-1:0]   req_now;
   logic                req_fire;
   logic [TIME_W-1:0]   elapsed, mag, period_new;
   logic [TIME_W-1:0]   pmag;
   logic                div_start, div_done;
   logic [DIV_N_W-1:0]  div_quo;
   logic [SPEED_W-1:0]  speed_mag;

   assign req_op  = req_tuser[0];
   assign req_pa  = req_tdata[0];
   assign req_pb  = req_tdata[1];
   assign req_now = req_tdata[33:2];

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // modulo-2^32 time since last edge; saturate to 31 bits for the period
   assign elapsed    = req_now - last_time_ff;
   assign mag        = elapsed[TIME_W-1] ? SPEED_MAX : elapsed;
   assign period_new = (req_pa == req_pb) ? (TIME_W'(0) - mag) : mag;
   assign pmag       = last_period_ff[TIME_W-1] ? (TIME_W'(0) - last_period_ff)
                                                : last_period_ff;

   assign div_start = req_fire && (req_op == OP_QUERY) && !(elapsed > timeout_ff)
                      && (last_period_ff != '0);

   qcps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scale_ff),
      .divisor  (pmag[DIV_D_W-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   // quotient limited to 2^31-1 before the sign goes back on
   assign speed_mag = (|div_quo[DIV_N_W-1:SPEED_W-1]) ? SPEED_MAX
                                                       : {1'b0, div_quo[SPEED_W-2:0]};

   always_comb begin
      state_in       = state_ff;
      scale_in       = scale_ff;
      timeout_in     = timeout_ff;
      count_in       = count_ff;
      last_time_in   = last_time_ff;
      last_period_in = last_period_ff;
      neg_in         = neg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      out_pos_in     = out_pos_ff;
      out_period_in  = out_period_ff;
      out_speed_in   = out_speed_ff;
      out_stopped_in = out_stopped_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED_SCALE:  scale_in   = csr_data;
            CSR_STOP_TIMEOUT: timeout_in = csr_data[TIME_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_EDGE) begin
                  count_in       = (req_pa == req_pb) ? count_ff - 1'b1 : count_ff + 1'b1;
                  last_period_in = period_new;
                  last_time_in   = req_now;
                  rsp_valid_in   = 1'b1;
                  out_pos_in     = (req_pa == req_pb) ? count_ff - 1'b1 : count_ff + 1'b1;
                  out_period_in  = period_new;
                  out_speed_in   = '0;
                  out_stopped_in = 1'b0;
               end else if (div_start) begin
                  neg_in   = last_period_ff[TIME_W-1];
                  state_in = ST_DIV;
               end else begin
                  // stopped, or zero period: answered at once
                  rsp_valid_in   = 1'b1;
                  out_pos_in     = count_ff;
                  out_period_in  = last_period_ff;
                  out_stopped_in = elapsed > timeout_ff;
                  out_speed_in   = (elapsed > timeout_ff) ? '0 : SPEED_MAX;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in   = 1'b1;
               out_pos_in     = count_ff;
               out_period_in  = last_period_ff;
               out_stopped_in = 1'b0;
               out_speed_in   = neg_ff ? (SPEED_W'(0) - speed_mag) : speed_mag;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         scale_ff       <= '0;
         timeout_ff     <= TIMEOUT_RESET;
         count_ff       <= '0;
         last_time_ff   <= LAST_TIME_RESET;
         last_period_ff <= PERIOD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scale_ff       <= scale_in;
         timeout_ff     <= timeout_in;
         count_ff       <= count_in;
         last_time_ff   <= last_time_in;
         last_period_ff <= last_period_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      neg_ff         <= neg_in;
      out_pos_ff     <= out_pos_in;
      out_period_ff  <= out_period_in;
      out_speed_ff   <= out_speed_in;
      out_stopped_ff <= out_stopped_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, out_stopped_ff, out_speed_ff, out_period_ff, out_pos_ff};

   // divider result only shows up while a query waits on it
   `QCPS_ASSERT(a_done_in_div, clock, reset, div_done |-> (state_ff == ST_DIV))
   // saturation keeps the stored period off -2^31
   `QCPS_ASSERT(a_period_range, clock, reset, last_period_ff != 32'h8000_0000)
   // a stopped result never carries a speed
   `QCPS_ASSERT(a_stopped_zero, clock, reset,
      (rsp_valid_ff && out_stopped_ff) |-> (out_speed_ff == '0))
   // edge transactions produce their result on the next cycle
   `QCPS_ASSERT(a_edge_latency, clock, reset,
      (req_fire && (req_op == OP_EDGE)) |=> rsp_valid_ff)

endmodule
`default_nettype wire

[rtl/qcps_div.sv]
`default_nettype none
// Radix-2 restoring divider, one quotient bit per cycle.
module qcps_div
   import qcps_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] dividend,
   input  wire logic [DIV_D_W-1:0] divisor,
   output logic                    done,
   output logic [DIV_N_W-1:0]      quotient
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_C_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] quo_ff, quo_in;
   logic [DIV_D_W:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0] dvs_ff, dvs_in;
   logic [DIV_D_W:0]   trial;
   logic [DIV_D_W:0]   diff;

   // remainder stays below divisor, so its top bit is always clear
   assign trial = {rem_ff[DIV_D_W-1:0], quo_ff[DIV_N_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_C_W'(DIV_N_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff;
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         if (cnt_ff == DIV_C_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire
